### rtl/pwt_pkg.sv
// Shared widths, register indexes and reset values for the PID twiddle unit.
// No dependencies; the design files refer to this package by scoped names, the test files import it.
`timescale 1ns / 1ps

package pwt_pkg;

	localparam int ERR_W      = 16;
	localparam int DIFF_W     = ERR_W + 1;
	localparam int GAIN_W     = 32;
	localparam int INTEG_W    = 40;
	localparam int INT_FRAC   = 20;
	localparam int SUM_W      = 48;
	localparam int LEN_W      = 12;
	localparam int PHASE_W    = LEN_W + 1;
	localparam int TOL_W      = 31;
	localparam int MUL_B_W    = INTEG_W - INT_FRAC + 1;
	localparam int PROD_W     = GAIN_W + MUL_B_W;
	localparam int ACC_W      = 74;
	localparam int OUT_SHIFT  = 12;
	localparam int OUT_W      = 32;
	localparam int DIV_W      = 37;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KI     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EVAL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd5;

	// gain slots in tuning order
	localparam logic [1:0] SLOT_P = 2'd0;
	localparam logic [1:0] SLOT_D = 2'd1;
	localparam logic [1:0] SLOT_I = 2'd2;

	localparam logic [LEN_W-1:0] SETTLE_RST = 12'd100;
	localparam logic [LEN_W-1:0] EVAL_RST   = 12'd1000;
	localparam logic [TOL_W-1:0] TOL_RST    = 31'd20972;

endpackage

### rtl/pwt_if.sv
// Valid/ready channel interfaces for error samples and control results.
// Depends on pwt_pkg for field widths.
`timescale 1ns / 1ps

interface pwt_err_if;
	logic                                valid;
	logic                                ready;
	logic signed [pwt_pkg::ERR_W-1:0]    error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink (input valid, input error_sample, output ready);
endinterface

interface pwt_ctl_if;
	logic                                valid;
	logic                                ready;
	logic signed [pwt_pkg::OUT_W-1:0]    control_value;
	logic                                tuning_active;

	modport source (output valid, output control_value, output tuning_active, input ready);
	modport sink (input valid, input control_value, input tuning_active, output ready);
endinterface

### rtl/pwt_div10.sv
// Floor division by ten of a signed word: shift-and-add reciprocal estimate,
// one add a cycle, then a remainder fix-up. Depends on pwt_pkg for the width.
`timescale 1ns / 1ps

module pwt_div10 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [pwt_pkg::DIV_W-1:0]   dividend,
	output logic                               done,
	output logic signed [pwt_pkg::DIV_W-1:0]   quotient
);
	localparam int W = pwt_pkg::DIV_W;
	localparam logic [W-1:0] NEG_BIAS = W'(10);
	localparam logic [W-1:0] REM_MAX  = W'(9);

	typedef enum logic [2:0] {
		DV_IDLE, DV_S4, DV_S8, DV_S16, DV_S32, DV_FIX
	} dv_state_t;

	dv_state_t           dv_q;
	logic                done_q;
	logic                neg_q;
	logic [W-1:0]        num_q;
	logic [W-1:0]        est_q;
	logic signed [W-1:0] quo_q;

	logic [W-1:0] mag;
	logic [W-1:0] rem;
	logic [W-1:0] fixed;

	// floor of a negative value: negate, add nine, divide, negate back
	assign mag   = dividend[W-1] ? (~dividend + NEG_BIAS) : dividend;
	assign rem   = num_q - ((est_q << 3) + (est_q << 1));
	assign fixed = est_q + ((rem > REM_MAX) ? W'(1) : W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q   <= DV_IDLE;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			num_q  <= '0;
			est_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (dv_q)
				DV_IDLE: begin
					if (start) begin
						neg_q <= dividend[W-1];
						num_q <= mag;
						est_q <= (mag >> 1) + (mag >> 2);
						dv_q  <= DV_S4;
					end
				end
				DV_S4: begin
					est_q <= est_q + (est_q >> 4);
					dv_q  <= DV_S8;
				end
				DV_S8: begin
					est_q <= est_q + (est_q >> 8);
					dv_q  <= DV_S16;
				end
				DV_S16: begin
					est_q <= est_q + (est_q >> 16);
					dv_q  <= DV_S32;
				end
				DV_S32: begin
					est_q <= (est_q + (est_q >> 32)) >> 3;
					dv_q  <= DV_FIX;
				end
				// estimate is low by at most one; the remainder tells
				DV_FIX: begin
					quo_q  <= neg_q ? -$signed(fixed) : $signed(fixed);
					done_q <= 1'b1;
					dv_q   <= DV_IDLE;
				end
				default: dv_q <= DV_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### rtl/pwt_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pwt_pkg for operand widths.
`timescale 1ns / 1ps

module pwt_mul (
	input  logic                                clk,
	input  logic signed [pwt_pkg::GAIN_W-1:0]   mul_a,
	input  logic signed [pwt_pkg::MUL_B_W-1:0]  mul_b,
	output logic signed [pwt_pkg::PROD_W-1:0]   prod_s1
);
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end
endmodule

### rtl/pid_with_twiddle_tuning_unit.sv
// Top level: PID controller with windowed twiddle gain tuning.
// Depends on pwt_pkg, pwt_if, pwt_mul and pwt_div10.
//
// channel     dir  payload                              handshake
// sample_in   in   error_sample (s16, Q8.8)             valid/ready
// result_out  out  control_value (s32), tuning_active   valid/ready
// cfg         in   cfg_index, cfg_data                  cfg_we, no wait
//
// Between acceptance and the next ready of an ordinary sample, one multiplier
// serves the square and the four gain products in turn. A window end with
// tuning on adds a shift-and-add divide by ten for each pending initial-gain
// delta and for each delta growth or shrink, plus a few steps. Reset sets all
// control state at once, but not the sample payload, product, accumulator or
// result value. The input is not ready while a sample is in work; a waiting
// result stalls the sequencer only at its last step.
`timescale 1ns / 1ps

module pid_with_twiddle_tuning_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	pwt_err_if.sink                               sample_in,
	pwt_ctl_if.source                             result_out,
	input  logic                                  cfg_we,
	input  logic [pwt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pwt_pkg::CFG_DATA_W-1:0]        cfg_data
);
	localparam int GW   = pwt_pkg::GAIN_W;
	localparam int SW   = GW + 3;
	localparam int DSW  = GW + 2;
	localparam int IW   = pwt_pkg::INTEG_W;
	localparam int FR   = pwt_pkg::INT_FRAC;
	localparam int AW   = pwt_pkg::ACC_W;
	localparam int SHW  = AW - pwt_pkg::OUT_SHIFT;
	localparam int OW   = pwt_pkg::OUT_W;
	localparam int DW   = pwt_pkg::DIV_W;
	localparam int BW   = pwt_pkg::MUL_B_W;
	localparam int SUMW = pwt_pkg::SUM_W;
	localparam int PW   = pwt_pkg::PHASE_W;

	localparam logic signed [DW-1:0] GROW_K   = DW'(11);
	localparam logic signed [DW-1:0] SHRINK_K = DW'(9);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SQA, ST_PEND, ST_PSTART, ST_PWAIT, ST_TW0, ST_GROW,
		ST_TW1, ST_SHRINK, ST_TOL, ST_M0, ST_M1, ST_M2, ST_M3, ST_OUT
	} state_t;

	function automatic logic signed [GW-1:0] sat_gain(input logic signed [SW-1:0] v);
		logic signed [GW-1:0] gmax;
		logic signed [GW-1:0] gmin;
		gmax = {1'b0, {(GW-1){1'b1}}};
		gmin = {1'b1, {(GW-1){1'b0}}};
		if (v > SW'(gmax))
			return gmax;
		else if (v < SW'(gmin))
			return gmin;
		else
			return v[GW-1:0];
	endfunction

	function automatic logic signed [GW-1:0] sat_div(input logic signed [DW-1:0] v);
		logic signed [GW-1:0] gmax;
		logic signed [GW-1:0] gmin;
		gmax = {1'b0, {(GW-1){1'b1}}};
		gmin = {1'b1, {(GW-1){1'b0}}};
		if (v > DW'(gmax))
			return gmax;
		else if (v < DW'(gmin))
			return gmin;
		else
			return v[GW-1:0];
	endfunction

	function automatic logic signed [OW-1:0] sat_out(input logic signed [SHW-1:0] v);
		logic signed [OW-1:0] omax;
		logic signed [OW-1:0] omin;
		omax = {1'b0, {(OW-1){1'b1}}};
		omin = {1'b1, {(OW-1){1'b0}}};
		if (v > SHW'(omax))
			return omax;
		else if (v < SHW'(omin))
			return omin;
		else
			return v[OW-1:0];
	endfunction

	function automatic logic [1:0] next_slot(input logic [1:0] s);
		return (s == pwt_pkg::SLOT_I) ? pwt_pkg::SLOT_P : s + 2'd1;
	endfunction

	state_t state_q;

	logic [pwt_pkg::LEN_W-1:0] settle_q;
	logic [pwt_pkg::LEN_W-1:0] eval_q;
	logic [pwt_pkg::TOL_W-1:0] tol_q;

	logic signed [GW-1:0] gain_q [3];
	logic signed [GW-1:0] delta_q [3];
	logic [2:0]           pend_q;
	logic [1:0]           sel_q;

	logic signed [pwt_pkg::ERR_W-1:0]  e_q;
	logic signed [pwt_pkg::ERR_W-1:0]  prev_q;
	logic signed [pwt_pkg::DIFF_W-1:0] diff_q;
	logic signed [IW-1:0]              integ_q;
	logic [PW-1:0]                     phase_q;
	logic [SUMW-1:0]                   ws_q;
	logic [SUMW-1:0]                   best_q;
	logic [1:0]                        ti_q;
	logic                              inc_q;
	logic                              dec_q;
	logic                              tune_q;
	logic                              first_q;
	logic                              end_q;
	logic                              accum_q;
	logic signed [AW-1:0]              acc_q;

	logic                  ov_q;
	logic signed [OW-1:0]  ctl_q;
	logic                  act_q;

	logic [1:0]                idx;
	logic signed [GW-1:0]      gain_r;
	logic signed [GW-1:0]      delta_r;
	logic [1:0]                pick;
	logic                      accept;
	logic                      first_now;
	logic [PW-1:0]             win_len;
	logic                      win_end;
	logic signed [IW:0]        integ_sum;
	logic signed [IW-1:0]      integ_n;
	logic [SUMW:0]             ws_sum;
	logic signed [SW-1:0]      amt_pos;
	logic signed [SW-1:0]      amt_neg;
	logic signed [DSW-1:0]     dsum;
	logic                      improve;
	logic                      try_none;
	logic                      try_inc;
	logic signed [AW-1:0]      acc_full;
	logic signed [SHW-1:0]     shifted_full;
	logic signed [SHW-1:0]     negated;
	logic                      out_load;

	logic signed [GW-1:0]                  mul_a;
	logic signed [BW-1:0]                  mul_b;
	logic signed [pwt_pkg::PROD_W-1:0]     prod_s1;
	logic                                  div_start;
	logic signed [DW-1:0]                  div_x;
	logic                                  div_done;
	logic signed [DW-1:0]                  div_q;

	assign idx     = (state_q == ST_PSTART || state_q == ST_PWAIT) ? sel_q : ti_q;
	assign gain_r  = gain_q[idx];
	assign delta_r = delta_q[idx];

	always_comb begin
		priority if (pend_q[0])
			pick = pwt_pkg::SLOT_P;
		else if (pend_q[1])
			pick = pwt_pkg::SLOT_D;
		else
			pick = pwt_pkg::SLOT_I;
	end

	assign accept    = sample_in.valid && sample_in.ready;
	assign first_now = first_q && (phase_q == PW'(1));
	assign win_len   = PW'(settle_q) + PW'(eval_q);
	assign win_end   = phase_q >= win_len;

	assign integ_sum = (IW+1)'(integ_q) + (IW+1)'(sample_in.error_sample);
	always_comb begin
		if (integ_sum[IW] != integ_sum[IW-1])
			integ_n = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
		else
			integ_n = integ_sum[IW-1:0];
	end

	assign ws_sum   = {1'b0, ws_q} + {1'b0, prod_s1[SUMW-1:0]};
	assign amt_pos  = SW'(delta_r);
	assign amt_neg  = -(amt_pos <<< 1);
	assign dsum     = DSW'(delta_q[0]) + DSW'(delta_q[1]) + DSW'(delta_q[2]);
	assign improve  = ws_q < best_q;
	assign try_none = !inc_q && !dec_q;
	assign try_inc  = inc_q && !dec_q;
	assign out_load = (state_q == ST_OUT) && (!ov_q || result_out.ready);

	// last product lands while the result is formed
	assign acc_full     = acc_q + AW'(prod_s1);
	assign shifted_full = acc_full[AW-1:pwt_pkg::OUT_SHIFT];
	assign negated      = -shifted_full;

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			ST_M0: begin
				mul_a = gain_q[pwt_pkg::SLOT_I];
				mul_b = BW'($signed(integ_q[IW-1:FR]));
			end
			ST_M1: begin
				mul_a = gain_q[pwt_pkg::SLOT_I];
				mul_b = $signed({1'b0, integ_q[FR-1:0]});
			end
			ST_M2: begin
				mul_a = gain_q[pwt_pkg::SLOT_P];
				mul_b = BW'(e_q);
			end
			// hold the derivative product while the result waits
			ST_M3, ST_OUT: begin
				mul_a = gain_q[pwt_pkg::SLOT_D];
				mul_b = BW'(diff_q);
			end
			default: begin
				mul_a = GW'(e_q);
				mul_b = BW'(e_q);
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_PSTART: begin
				div_start = 1'b1;
				div_x     = DW'(gain_r);
			end
			ST_TW0: begin
				div_start = improve && !first_q;
				div_x     = DW'(delta_r) * GROW_K;
			end
			ST_TW1: begin
				div_start = !try_none && !try_inc;
				div_x     = DW'(delta_r) * SHRINK_K;
			end
			default: begin
				div_start = 1'b0;
				div_x     = '0;
			end
		endcase
	end

	pwt_mul u_mul (
		.clk     (clk),
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.prod_s1 (prod_s1)
	);

	pwt_div10 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_x),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			settle_q <= pwt_pkg::SETTLE_RST;
			eval_q   <= pwt_pkg::EVAL_RST;
			tol_q    <= pwt_pkg::TOL_RST;
			for (int k = 0; k < 3; k++) begin
				gain_q[k]  <= '0;
				delta_q[k] <= '0;
			end
			pend_q   <= '0;
			sel_q    <= pwt_pkg::SLOT_P;
			prev_q   <= '0;
			integ_q  <= '0;
			phase_q  <= PW'(1);
			ws_q     <= '0;
			best_q   <= '1;
			ti_q     <= pwt_pkg::SLOT_I;
			inc_q    <= 1'b0;
			dec_q    <= 1'b0;
			tune_q   <= 1'b1;
			first_q  <= 1'b1;
			end_q    <= 1'b0;
			accum_q  <= 1'b0;
			ov_q     <= 1'b0;
			act_q    <= 1'b0;
		end else begin
			if (out_load)
				ov_q <= 1'b1;
			else if (result_out.ready)
				ov_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q  <= sample_in.error_sample;
						integ_q <= integ_n;
						end_q   <= win_end;
						accum_q <= !win_end && (phase_q > PW'(settle_q));
						phase_q <= win_end ? PW'(1) : phase_q + PW'(1);
						state_q <= ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_SQA;
				ST_SQA: begin
					if (end_q) begin
						if (tune_q) begin
							state_q <= ST_PEND;
						end else begin
							ws_q    <= '0;
							first_q <= 1'b0;
							state_q <= ST_M0;
						end
					end else begin
						if (accum_q)
							ws_q <= ws_sum[SUMW] ? '1 : ws_sum[SUMW-1:0];
						state_q <= ST_M0;
					end
				end
				// resolve deltas of freshly written initial gains
				ST_PEND: begin
					if (pend_q == '0) begin
						state_q <= ST_TW0;
					end else begin
						sel_q   <= pick;
						state_q <= ST_PSTART;
					end
				end
				ST_PSTART: state_q <= ST_PWAIT;
				ST_PWAIT: begin
					if (div_done) begin
						delta_q[sel_q] <= sat_div(div_q);
						pend_q[sel_q]  <= 1'b0;
						state_q        <= ST_PEND;
					end
				end
				ST_TW0: begin
					if (improve) begin
						best_q <= ws_q;
						if (first_q) begin
							ti_q    <= next_slot(ti_q);
							inc_q   <= 1'b0;
							dec_q   <= 1'b0;
							state_q <= ST_TW1;
						end else begin
							state_q <= ST_GROW;
						end
					end else begin
						state_q <= ST_TW1;
					end
				end
				ST_GROW: begin
					if (div_done) begin
						delta_q[ti_q] <= sat_div(div_q);
						ti_q    <= next_slot(ti_q);
						inc_q   <= 1'b0;
						dec_q   <= 1'b0;
						state_q <= ST_TW1;
					end
				end
				ST_TW1: begin
					priority if (try_none) begin
						gain_q[ti_q] <= sat_gain(SW'(gain_r) + amt_pos);
						inc_q        <= 1'b1;
						state_q      <= ST_TOL;
					end else if (try_inc) begin
						gain_q[ti_q] <= sat_gain(SW'(gain_r) + amt_neg);
						dec_q        <= 1'b1;
						state_q      <= ST_TOL;
					end else begin
						gain_q[ti_q] <= sat_gain(SW'(gain_r) + amt_pos);
						state_q      <= ST_SHRINK;
					end
				end
				ST_SHRINK: begin
					if (div_done) begin
						delta_q[ti_q] <= sat_div(div_q);
						ti_q    <= next_slot(ti_q);
						inc_q   <= 1'b0;
						dec_q   <= 1'b0;
						state_q <= ST_TOL;
					end
				end
				ST_TOL: begin
					if (dsum < $signed(DSW'({1'b0, tol_q})))
						tune_q <= 1'b0;
					ws_q    <= '0;
					first_q <= 1'b0;
					state_q <= ST_M0;
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						act_q   <= tune_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cfg_we) begin
				unique case (cfg_index)
					pwt_pkg::CFG_KP: begin
						gain_q[pwt_pkg::SLOT_P] <= cfg_data[GW-1:0];
						pend_q[pwt_pkg::SLOT_P] <= 1'b1;
					end
					pwt_pkg::CFG_KI: begin
						gain_q[pwt_pkg::SLOT_I] <= cfg_data[GW-1:0];
						pend_q[pwt_pkg::SLOT_I] <= 1'b1;
					end
					pwt_pkg::CFG_KD: begin
						gain_q[pwt_pkg::SLOT_D] <= cfg_data[GW-1:0];
						pend_q[pwt_pkg::SLOT_D] <= 1'b1;
					end
					pwt_pkg::CFG_SETTLE: settle_q <= cfg_data[pwt_pkg::LEN_W-1:0];
					pwt_pkg::CFG_EVAL:   eval_q   <= cfg_data[pwt_pkg::LEN_W-1:0];
					pwt_pkg::CFG_TOL:    tol_q    <= cfg_data[pwt_pkg::TOL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// sample payload and product accumulation
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q    <= sample_in.error_sample;
			diff_q <= first_now ? '0
				: pwt_pkg::DIFF_W'(sample_in.error_sample) - pwt_pkg::DIFF_W'(prev_q);
		end
		unique case (state_q)
			ST_M1:        acc_q <= AW'(prod_s1) <<< FR;
			ST_M2, ST_M3: acc_q <= acc_q + AW'(prod_s1);
			default:      acc_q <= acc_q;
		endcase
		if (out_load)
			ctl_q <= sat_out(negated);
	end

	assign sample_in.ready          = (state_q == ST_IDLE);
	assign result_out.valid         = ov_q;
	assign result_out.control_value = ctl_q;
	assign result_out.tuning_active = act_q;
endmodule

### test/pid_with_twiddle_tuning_checker.sv
// Checker for the PID twiddle unit: mirrors the configuration writes, predicts
// each control beat from the accepted error samples and compares field by field.
// Depends on pwt_pkg and the channel interfaces in pwt_if.
`timescale 1ns / 1ps

module pid_with_twiddle_tuning_checker (
	input  logic clk,
	input  logic arst_n,
	pwt_err_if   sample_in,
	pwt_ctl_if   result_out,
	input  logic                            cfg_we,
	input  logic [pwt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pwt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int   mismatches,
	output int   pending,
	output int   results_seen,
	output int   window_ends
);
	import pwt_pkg::*;

	typedef struct packed {
		logic signed [OUT_W-1:0] control_value;
		logic                    tuning_active;
	} ctl_beat_t;

	localparam longint SUM_MAX = (longint'(1) << SUM_W) - 1;

	ctl_beat_t expected_ctl[$];

	// predictor state
	longint gain_p, gain_i, gain_d;
	longint step_size[3];
	longint last_err, err_integ;
	int     phase;
	longint win_sum, best_sum;
	logic [1:0] slot;
	logic   went_up, went_down, tune_on, first_win;
	longint settle_len, eval_len, tolerance;

	function automatic longint clamp(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint fdiv(longint v, longint d);
		longint q;
		q = v / d;
		if (v % d != 0 && v < 0)
			q--;
		return q;
	endfunction

	task automatic bump_gain(logic [1:0] s, longint amount);
		case (s)
			SLOT_P: gain_p = clamp(gain_p + amount, GAIN_W);
			SLOT_D: gain_d = clamp(gain_d + amount, GAIN_W);
			default: gain_i = clamp(gain_i + amount, GAIN_W);
		endcase
	endtask

	function automatic logic [1:0] next_slot(logic [1:0] s);
		return (s == SLOT_I) ? SLOT_P : s + 2'd1;
	endfunction

	task automatic twiddle_step();
		if (win_sum < best_sum) begin
			best_sum = win_sum;
			if (!first_win)
				step_size[slot] = clamp(fdiv(step_size[slot] * 11, 10), GAIN_W);
			slot = next_slot(slot);
			went_up = 1'b0;
			went_down = 1'b0;
		end
		if (!went_up && !went_down) begin
			bump_gain(slot, step_size[slot]);
			went_up = 1'b1;
		end else if (went_up && !went_down) begin
			bump_gain(slot, -2 * step_size[slot]);
			went_down = 1'b1;
		end else begin
			bump_gain(slot, step_size[slot]);
			step_size[slot] = clamp(fdiv(step_size[slot] * 9, 10), GAIN_W);
			slot = next_slot(slot);
			went_up = 1'b0;
			went_down = 1'b0;
		end
		if (step_size[0] + step_size[1] + step_size[2] < tolerance)
			tune_on = 1'b0;
	endtask

	task automatic predict_control(logic signed [ERR_W-1:0] sample);
		longint e, diff, hi, lo, a, b, c, sq;
		ctl_beat_t beat;
		e = longint'(sample);
		diff = (first_win && phase == 1) ? 0 : e - last_err;
		last_err = e;
		err_integ = clamp(err_integ + e, INTEG_W);
		if (longint'(phase) >= settle_len + eval_len) begin
			if (tune_on)
				twiddle_step();
			window_ends++;
			win_sum = 0;
			first_win = 1'b0;
			phase = 1;
		end else begin
			if (longint'(phase) > settle_len) begin
				sq = e * e;
				win_sum = (SUM_MAX - win_sum < sq) ? SUM_MAX : win_sum + sq;
			end
			phase++;
		end
		hi = fdiv(err_integ, longint'(1) << INT_FRAC);
		lo = err_integ - hi * (longint'(1) << INT_FRAC);
		a = gain_i * hi;
		b = gain_i * lo + gain_p * e + gain_d * diff;
		c = clamp(-(a * 256 + fdiv(b, 4096)), OUT_W);
		beat.control_value = c[OUT_W-1:0];
		beat.tuning_active = tune_on;
		expected_ctl.push_back(beat);
	endtask

	task automatic report(string what, longint got, longint want);
		$display("%0t mismatch on %s: got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ctl_beat_t want;
		if (!arst_n) begin
			gain_p = 0; gain_i = 0; gain_d = 0;
			step_size[0] = 0; step_size[1] = 0; step_size[2] = 0;
			last_err = 0; err_integ = 0; phase = 1;
			win_sum = 0; best_sum = SUM_MAX; slot = SLOT_I;
			went_up = 1'b0; went_down = 1'b0; tune_on = 1'b1; first_win = 1'b1;
			settle_len = SETTLE_RST; eval_len = EVAL_RST; tolerance = TOL_RST;
			expected_ctl.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KP: begin
						gain_p = longint'($signed(cfg_data));
						step_size[SLOT_P] = fdiv(gain_p, 10);
					end
					CFG_KI: begin
						gain_i = longint'($signed(cfg_data));
						step_size[SLOT_I] = fdiv(gain_i, 10);
					end
					CFG_KD: begin
						gain_d = longint'($signed(cfg_data));
						step_size[SLOT_D] = fdiv(gain_d, 10);
					end
					CFG_SETTLE: settle_len = cfg_data[LEN_W-1:0];
					CFG_EVAL:   eval_len = cfg_data[LEN_W-1:0];
					CFG_TOL:    tolerance = cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end
			if (sample_in.valid && sample_in.ready)
				predict_control(sample_in.error_sample);
			if (result_out.valid && result_out.ready) begin
				results_seen++;
				if (expected_ctl.size() == 0) begin
					$display("%0t control beat with nothing expected", $time);
					mismatches++;
				end else begin
					want = expected_ctl.pop_front();
					if (result_out.control_value !== want.control_value)
						report("control_value", result_out.control_value,
							want.control_value);
					if (result_out.tuning_active !== want.tuning_active)
						report("tuning_active", result_out.tuning_active,
							want.tuning_active);
				end
			end
		end
		pending = expected_ctl.size();
	end

	initial begin
		mismatches = 0;
		pending = 0;
		results_seen = 0;
		window_ends = 0;
	end
endmodule

### test/pid_with_twiddle_tuning_unit_tb.sv
// Top of the PID twiddle unit bench: clock, reset, sample and config stimulus,
// random back-pressure, watchdog and verdict. Depends on pwt_pkg, pwt_if, the
// unit itself and pid_with_twiddle_tuning_checker.
`timescale 1ns / 1ps

module pid_with_twiddle_tuning_unit_tb;
	import pwt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 3'd7;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic steady = 1'b0;
	int   quiet = 0;
	int   samples_sent = 0;
	int   mismatches, pending, results_seen, window_ends;

	pwt_err_if sample_ch ();
	pwt_ctl_if result_ch ();

	pid_with_twiddle_tuning_unit DUT (
		.clk(clk), .arst_n(arst_n), .sample_in(sample_ch), .result_out(result_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pid_with_twiddle_tuning_checker u_checker (
		.clk(clk), .arst_n(arst_n), .sample_in(sample_ch), .result_out(result_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending), .results_seen(results_seen),
		.window_ends(window_ends)
	);

	always #5 clk = ~clk;

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.error_sample = '0;
		result_ch.ready = 1'b0;
	end

	// watchdog: count cycles without any beat
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog expired, %0d control beats outstanding", pending);
			$display("pid_with_twiddle_tuning_unit_tb NOT OK");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	task automatic send_sample(logic [ERR_W-1:0] e);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.error_sample <= e;
		do @(posedge clk); while (!sample_ch.ready);
		samples_sent++;
	endtask

	function automatic logic [ERR_W-1:0] rand_error();
		if ($urandom_range(0, 3) == 0)
			return ERR_W'($urandom());
		return ERR_W'($urandom_range(0, 512) - 256);
	endfunction

	// drop valid, drain every outstanding beat and let a window end finish
	task automatic settle_down();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic set_gains(logic [CFG_DATA_W-1:0] kp, ki, kd);
		write_reg(CFG_KP, kp);
		write_reg(CFG_KI, ki);
		write_reg(CFG_KD, kd);
	endtask

	task automatic set_window(int settle, int evl);
		write_reg(CFG_SETTLE, settle);
		write_reg(CFG_EVAL, evl);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_run(int n);
		repeat (n) send_sample(rand_error());
	endtask

	initial begin
		logic [ERR_W-1:0] directed[$];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero tolerance keeps tuning alive while all deltas stay non-negative
		write_reg(CFG_TOL, 31'd0);
		set_gains(32'h0010_0000, 32'h0001_0000, 32'h0008_0000);
		set_window(0, 1);
		directed = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h7FFF,
			16'h7FFF, 16'h8000, 16'h8000, 16'h0100, 16'hFF00, 16'h5555, 16'hAAAA,
			16'h0000, 16'h0000, 16'h7FFF, 16'h8001, 16'h0080, 16'hFF80, 16'h0000};
		foreach (directed[k])
			send_sample(directed[k]);
		settle_down();

		// largest gains saturate the products and the twiddle steps
		set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		set_window(2, 3);
		random_run(80);
		settle_down();

		// zero-length window: every sample ends one
		write_reg(CFG_SPARE, $urandom());
		write_reg(CFG_TOP, $urandom());
		set_window(0, 0);
		random_run(60);
		settle_down();

		for (int ph = 0; ph < 8; ph++) begin
			steady <= (ph % 3 == 2);
			if ($urandom_range(0, 1))
				set_gains($urandom() & 32'h7FFF_FFFF, $urandom() & 32'h00FF_FFFF,
					$urandom() & 32'h0FFF_FFFF);
			set_window($urandom_range(0, 6), $urandom_range(1, 12));
			random_run(100);
			settle_down();
		end
		steady <= 1'b0;

		// longest window, only partly walked
		set_window(4095, 4095);
		random_run(40);
		settle_down();

		// negative gains and the widest tolerance stop tuning for good
		write_reg(CFG_TOL, 31'h7FFF_FFFF);
		set_gains(32'h8000_0000, $urandom() | 32'h8000_0000, $urandom() | 32'h8000_0000);
		set_window($urandom_range(0, 3), $urandom_range(1, 6));
		random_run(150);
		settle_down();

		$display("sent %0d error samples, checked %0d control beats", samples_sent,
			results_seen);
		$display("predicted %0d window ends across 13 register settings", window_ends);
		if (mismatches == 0)
			$display("pid_with_twiddle_tuning_unit_tb OK");
		else
			$display("pid_with_twiddle_tuning_unit_tb NOT OK");
		$finish;
	end
endmodule
